### hdl/haversine_move_refresh_trigger_top_defines.svh
// assertion macros shared by the rtl
`ifndef HAVERSINE_MOVE_REFRESH_TRIGGER_TOP_DEFINES_SVH
`define HAVERSINE_MOVE_REFRESH_TRIGGER_TOP_DEFINES_SVH

// same-cycle implication
`define HMRT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("hmrt assertion failed");

// next-cycle implication
`define HMRT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("hmrt assertion failed");

`endif

### hdl/hmrt_pkg.sv
package hmrt_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int TIME_W = 40;
  localparam int DIST_W = 23;
  localparam int CAUSE_W = 3;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] CAUSE_SKIP    = 3'd0;
  localparam logic [2:0] CAUSE_NONE    = 3'd1;
  localparam logic [2:0] CAUSE_FIRST   = 3'd2;
  localparam logic [2:0] CAUSE_MOVED   = 3'd3;
  localparam logic [2:0] CAUSE_EXPIRED = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_INTERVAL = 8'd1;

  localparam logic [22:0] MOVE_THRESHOLD_RST = 23'd7680;
  localparam logic [31:0] REFRESH_INTERVAL_RST = 32'd21600000;

  localparam logic [31:0] RAD_SCALE    = 32'd503056907;
  localparam logic [31:0] EARTH_RADIUS = 32'd6371;
  localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [30:0] Q30_ONE = 31'd1073741824;
  localparam logic [22:0] DIST_MAX = 23'd5242879;

  localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;
  localparam logic signed [31:0] LON_LIMIT = 32'sd1800000000;

  // round(atan(2^-i) * 2^30)
  function automatic logic [29:0] atan_tab(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd31: v = 30'd0;
      default: v = 30'd1 << (5'd30 - i);
    endcase
    return v;
  endfunction

  // clamp to [0, 1.0] in q2.30
  function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
    logic [30:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({3'b0, Q30_ONE})) begin
      r = Q30_ONE;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

### hdl/hmrt_if.sv
interface hmrt_in_if;
  import hmrt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      network_ok;
  logic                      fix_valid;
  logic signed [LAT_W-1:0]   latitude;
  logic signed [LON_W-1:0]   longitude;
  logic        [TIME_W-1:0]  time_ms;

  modport source (output valid, network_ok, fix_valid, latitude, longitude, time_ms,
                  input ready);
  modport sink   (input valid, network_ok, fix_valid, latitude, longitude, time_ms,
                  output ready);
endinterface

interface hmrt_out_if;
  import hmrt_pkg::*;
  logic                valid;
  logic                ready;
  logic                update;
  logic [CAUSE_W-1:0]  cause;
  logic [DIST_W-1:0]   distance;

  modport source (output valid, update, cause, distance, input ready);
  modport sink   (input valid, update, cause, distance, output ready);
endinterface

### hdl/haversine_move_refresh_trigger_top.sv
// Position-check trigger: each input beat is one check (network flag, fix flag, latitude and
// longitude in 1e-7 degree, time in ms) and yields exactly one result beat (update flag, cause,
// distance in 1/256 km). A skipped check or the first fix answers in the cycle after acceptance;
// a full check runs the haversine distance through one shared datapath (a 32x32 multiplier,
// a CORDIC stage and a 2-bit-per-step integer root) in this order: four CORDIC rotations, four
// rounded products, two 32-step roots, one CORDIC vectoring pass and the final scale.
// The block takes one check at a time and is not ready until its result beat has left.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while idle, as the block itself does not enforce it.
module haversine_move_refresh_trigger_top #(
  parameter int CORDIC_STEPS = hmrt_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  hmrt_in_if.sink                         check_in,
  hmrt_out_if.source                      result,
  input  logic                            cfg_we,
  input  logic [hmrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hmrt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hmrt_pkg::*;

  `include "haversine_move_refresh_trigger_top_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_RAD_MUL, S_RAD_RND, S_ROT, S_QMUL, S_QRES, S_SQRT, S_VEC, S_DMUL, S_DRES
  } state_t;

  localparam logic [4:0] LAST_IT = 5'(CORDIC_STEPS - 1);

  state_t state;

  // configuration
  logic [22:0] move_threshold;
  logic [31:0] refresh_interval_ms;

  // stored fix
  logic signed [31:0] stored_lat;
  logic signed [31:0] stored_lon;
  logic [TIME_W-1:0]  stored_time;
  logic               have_fix;

  // current check, coordinates already saturated
  logic signed [31:0] cur_lat;
  logic signed [31:0] cur_lon;
  logic [TIME_W-1:0]  cur_time;

  // sequencer counters
  logic [1:0] job;     // cos lat1, cos lat2, sin dlat/2, sin dlon/2
  logic [1:0] qstep;
  logic       sq_job;  // root of a, then root of 1-a
  logic [4:0] it;
  logic [4:0] k;

  // working registers
  logic [63:0]        prod;
  logic signed [33:0] cx, cy, cz;
  logic [30:0]        c1, c2, s1, s2, a_reg, ry;
  logic [60:0]        sq_n;
  logic [62:0]        sq_r;

  // result register
  logic              out_valid;
  logic              out_update;
  logic [2:0]        out_cause;
  logic [DIST_W-1:0] out_dist;

  // combinational
  logic               in_fire;
  logic signed [31:0] in_lat_sat, in_lon_sat;
  logic signed [32:0] ang;
  logic               ang_neg;
  logic [32:0]        ang_abs;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        rad_sum;
  logic signed [33:0] rad_m, half_red;
  logic signed [33:0] dx, dy, atan_v, cx_n, cy_n, cz_n;
  logic               sigma;
  logic [30:0]        qres;
  logic [31:0]        a_sum;
  logic [30:0]        a_clamp;
  logic [62:0]        sq_bit, sq_trial, sq_r_n;
  logic [60:0]        sq_n_n;
  logic               sq_ge;
  logic [63:0]        d_sum;
  logic [DIST_W-1:0]  d_sat;
  logic [TIME_W-1:0]  elapsed;
  logic [2:0]         cause_n;

  assign in_fire = check_in.valid && check_in.ready;
  assign check_in.ready = (state == S_IDLE) && !out_valid;

  assign result.valid    = out_valid;
  assign result.update   = out_update;
  assign result.cause    = out_cause;
  assign result.distance = out_dist;

  // saturate incoming coordinates
  always_comb begin
    in_lat_sat = 32'(check_in.latitude);
    if (in_lat_sat > LAT_LIMIT) begin
      in_lat_sat = LAT_LIMIT;
    end else if (in_lat_sat < -LAT_LIMIT) begin
      in_lat_sat = -LAT_LIMIT;
    end
    in_lon_sat = check_in.longitude;
    if (in_lon_sat > LON_LIMIT) begin
      in_lon_sat = LON_LIMIT;
    end else if (in_lon_sat < -LON_LIMIT) begin
      in_lon_sat = -LON_LIMIT;
    end
  end

  // angle feeding the degree-to-radian product for the current trig job
  always_comb begin
    case (job)
      2'd0:    ang = 33'(stored_lat);
      2'd1:    ang = 33'(cur_lat);
      2'd2:    ang = 33'(cur_lat) - 33'(stored_lat);
      default: ang = 33'(cur_lon) - 33'(stored_lon);
    endcase
    ang_neg = ang[32];
    ang_abs = ang_neg ? 33'(-ang) : 33'(ang);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RAD_MUL: begin
        mul_a = ang_abs[31:0];
        mul_b = RAD_SCALE;
      end
      S_QMUL: begin
        case (qstep)
          2'd0:    begin mul_a = 32'(c1); mul_b = 32'(c2); end
          2'd1:    begin mul_a = 32'(s1); mul_b = 32'(s1); end
          2'd2:    begin mul_a = 32'(s2); mul_b = 32'(s2); end
          default: begin mul_a = 32'(c1); mul_b = 32'(s2); end
        endcase
      end
      S_DMUL: begin
        mul_a = cz[31:0];
        mul_b = EARTH_RADIUS;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // radian rounding: full angle for the cosines, half angle for the sines
  always_comb begin
    if (job[1]) begin
      rad_sum = (prod + 64'(1) * (64'd1 << 28)) >> 29;
    end else begin
      rad_sum = (prod + (64'd1 << 27)) >> 28;
    end
    rad_m = $signed({1'b0, rad_sum[32:0]});
    half_red = (rad_m > Q30_HALF_PI) ? (Q30_PI - rad_m) : rad_m;
  end

  // one cordic micro-rotation, rotation or vectoring mode
  always_comb begin
    dx = cy >>> it;
    dy = cx >>> it;
    atan_v = $signed({4'b0, atan_tab(it)});
    if (state == S_ROT) begin
      sigma = !cz[33];
    end else begin
      sigma = cy[33] || (cy == 0);
    end
    if (sigma) begin
      cx_n = cx - dx;
      cy_n = cy + dy;
      cz_n = cz - atan_v;
    end else begin
      cx_n = cx + dx;
      cy_n = cy - dy;
      cz_n = cz + atan_v;
    end
  end

  // rounded q2.30 product and haversine sum
  always_comb begin
    qres = 31'((prod + (64'd1 << 29)) >> 30);
    a_sum = 32'(s1) + 32'(qres);
    a_clamp = (a_sum > 32'(Q30_ONE)) ? Q30_ONE : a_sum[30:0];
  end

  // one step of the bitwise integer root
  always_comb begin
    sq_bit = 63'd1 << {k, 1'b0};
    sq_trial = sq_r + sq_bit;
    sq_ge = {2'b0, sq_n} >= sq_trial;
    if (sq_ge) begin
      sq_n_n = 61'({2'b0, sq_n} - sq_trial);
      sq_r_n = (sq_r >> 1) + sq_bit;
    end else begin
      sq_n_n = sq_n;
      sq_r_n = sq_r >> 1;
    end
  end

  // distance scale and decision
  always_comb begin
    d_sum = (prod + (64'd1 << 20)) >> 21;
    d_sat = (d_sum > 64'(DIST_MAX)) ? DIST_MAX : d_sum[DIST_W-1:0];
    elapsed = cur_time - stored_time;
    if (d_sat > move_threshold) begin
      cause_n = CAUSE_MOVED;
    end else if (elapsed > TIME_W'(refresh_interval_ms)) begin
      cause_n = CAUSE_EXPIRED;
    end else begin
      cause_n = CAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
    if (rst) begin
      state <= S_IDLE;
      move_threshold <= MOVE_THRESHOLD_RST;
      refresh_interval_ms <= REFRESH_INTERVAL_RST;
      stored_lat <= '0;
      stored_lon <= '0;
      stored_time <= '0;
      have_fix <= 1'b0;
      out_valid <= 1'b0;
      job <= '0;
      qstep <= '0;
      sq_job <= 1'b0;
      it <= '0;
      k <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MOVE_THRESHOLD) begin
          move_threshold <= cfg_data[22:0];
        end else if (cfg_index == REG_REFRESH_INTERVAL) begin
          refresh_interval_ms <= cfg_data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (out_valid && result.ready) begin
            out_valid <= 1'b0;
          end
          if (in_fire) begin
            cur_lat <= in_lat_sat;
            cur_lon <= in_lon_sat;
            cur_time <= check_in.time_ms;
            if (!check_in.network_ok || !check_in.fix_valid) begin
              out_valid <= 1'b1;
              out_update <= 1'b0;
              out_cause <= CAUSE_SKIP;
              out_dist <= '0;
            end else if (!have_fix) begin
              out_valid <= 1'b1;
              out_update <= 1'b1;
              out_cause <= CAUSE_FIRST;
              out_dist <= '0;
              stored_lat <= in_lat_sat;
              stored_lon <= in_lon_sat;
              stored_time <= check_in.time_ms;
              have_fix <= 1'b1;
            end else begin
              job <= '0;
              state <= S_RAD_MUL;
            end
          end
        end
        S_RAD_MUL: begin
          state <= S_RAD_RND;
        end
        S_RAD_RND: begin
          if (job[1]) begin
            cz <= half_red;
          end else begin
            cz <= ang_neg ? -rad_m : rad_m;
          end
          cx <= CORDIC_GAIN;
          cy <= '0;
          it <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          cx <= cx_n;
          cy <= cy_n;
          cz <= cz_n;
          it <= it + 5'd1;
          if (it == LAST_IT) begin
            case (job)
              2'd0:    c1 <= clamp_unit(cx_n);
              2'd1:    c2 <= clamp_unit(cx_n);
              2'd2:    s1 <= clamp_unit(cy_n);
              default: s2 <= clamp_unit(cy_n);
            endcase
            if (job == 2'd3) begin
              qstep <= '0;
              state <= S_QMUL;
            end else begin
              job <= job + 2'd1;
              state <= S_RAD_MUL;
            end
          end
        end
        S_QMUL: begin
          state <= S_QRES;
        end
        S_QRES: begin
          qstep <= qstep + 2'd1;
          state <= S_QMUL;
          case (qstep)
            2'd0: c1 <= qres;
            2'd1: s1 <= qres;
            2'd2: s2 <= qres;
            default: begin
              // a = sin^2(dlat/2) + cc * sin^2(dlon/2), then root of a first
              a_reg <= a_clamp;
              sq_n <= 61'(a_clamp) << 30;
              sq_r <= '0;
              k <= 5'd31;
              sq_job <= 1'b0;
              state <= S_SQRT;
            end
          endcase
        end
        S_SQRT: begin
          sq_n <= sq_n_n;
          sq_r <= sq_r_n;
          k <= k - 5'd1;
          if (k == 5'd0) begin
            if (!sq_job) begin
              ry <= sq_r_n[30:0];
              sq_job <= 1'b1;
              sq_n <= 61'(Q30_ONE - a_reg) << 30;
              sq_r <= '0;
              k <= 5'd31;
            end else begin
              cx <= $signed({3'b0, sq_r_n[30:0]});
              cy <= $signed({3'b0, ry});
              cz <= '0;
              it <= '0;
              state <= S_VEC;
            end
          end
        end
        S_VEC: begin
          cx <= cx_n;
          cy <= cy_n;
          cz <= cz_n;
          it <= it + 5'd1;
          if (it == LAST_IT) begin
            cz <= cz_n[33] ? 34'sd0 : cz_n;
            state <= S_DMUL;
          end
        end
        S_DMUL: begin
          state <= S_DRES;
        end
        S_DRES: begin
          out_valid <= 1'b1;
          out_update <= (cause_n != CAUSE_NONE);
          out_cause <= cause_n;
          out_dist <= d_sat;
          if (cause_n != CAUSE_NONE) begin
            stored_lat <= cur_lat;
            stored_lon <= cur_lon;
            stored_time <= cur_time;
            have_fix <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // one check in flight at a time
  `HMRT_ASSERT_NXT(a_busy_after_beat, clk, rst, in_fire, !check_in.ready)
  // the update flag follows the cause: first fix, moved and expired update
  `HMRT_ASSERT_IMP(a_update_cause, clk, rst, out_valid, out_update == (out_cause > CAUSE_NONE))
  // skipped checks report no distance
  `HMRT_ASSERT_IMP(a_skip_zero, clk, rst, out_valid && (out_cause == CAUSE_SKIP), out_dist == 0)
  // an update always leaves a stored fix behind
  `HMRT_ASSERT_IMP(a_update_stores, clk, rst, out_valid && out_update, have_fix)

endmodule

### dv/tb.sv
module tb;
  import hmrt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run limits: receiver stalls can more than double the time a full check takes
  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam int     DRAIN_CYCLES = 260;
  localparam int     HOLD_CYCLES = 900;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam longint CLAMP_LAT = 900000000;
  localparam longint CLAMP_LON = 1800000000;
  localparam longint UNIT_Q30 = 64'd1073741824;
  localparam longint PI_Q30 = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;
  localparam longint GAIN_Q30 = 64'd652032874;
  localparam longint DEG_TO_RAD = 64'd503056907;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hmrt_in_if  check_in ();
  hmrt_out_if result ();

  haversine_move_refresh_trigger_top dut (
    .clk(clk),
    .rst(rst),
    .check_in(check_in.sink),
    .result(result.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // one expected result beat
  typedef struct {
    logic                update;
    logic [CAUSE_W-1:0]  cause;
    logic [DIST_W-1:0]   distance;
  } verdict_t;

  verdict_t pending_verdicts[$];

  // predictor copy of the block state and its registers
  longint           prev_lat;
  longint           prev_lon;
  bit               last_fix;
  logic [TIME_W-1:0] last_time;
  logic [22:0]      thr_reg;
  logic [31:0]      intv_reg;

  int  errors;
  longint cycles;
  int  tx_idle_pct;
  int  rx_stall_pct;
  int  hold_left;

  // stimulus tracking: current position and clock
  longint cur_lat;
  longint cur_lon;
  logic [TIME_W-1:0] now_ms;

  longint arctan_q30 [32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149,
    1048576, 524288, 262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
  };

  // 1e-7 degree to q2.30 radians, s = 28 full angle, 29 half angle
  function automatic longint deg7_to_rad(longint v, int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m * DEG_TO_RAD + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic void rotate_q30(longint ang, output longint sn, output longint cs);
    longint x, y, z, dx, dy;
    x = GAIN_Q30;
    y = 0;
    z = ang;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q30[i];
      end else begin
        x += dx; y -= dy; z += arctan_q30[i];
      end
    end
    sn = y;
    cs = x;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += arctan_q30[i];
      end else begin
        x -= dx; y += dy; z -= arctan_q30[i];
      end
    end
    return (z < 0) ? 0 : z;
  endfunction

  function automatic longint unit_clamp(longint v);
    return (v < 0) ? 0 : ((v > UNIT_Q30) ? UNIT_Q30 : v);
  endfunction

  function automatic longint root64(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint half_sine(longint diff);
    longint h, sn, cs;
    h = deg7_to_rad(diff, 29);
    if (h < 0) h = -h;
    if (h > HALF_PI_Q30) h = PI_Q30 - h;
    rotate_q30(h, sn, cs);
    return unit_clamp(sn);
  endfunction

  function automatic longint lat_cosine(longint lat);
    longint sn, cs;
    rotate_q30(deg7_to_rad(lat, 28), sn, cs);
    return unit_clamp(cs);
  endfunction

  // great-circle distance in 1/256 km, saturated
  function automatic longint great_circle(longint la1, longint lo1, longint la2, longint lo2);
    longint s1, s2, cc, a, z, d;
    s1 = half_sine(la2 - la1);
    s2 = half_sine(lo2 - lo1);
    cc = mul_q30(lat_cosine(la1), lat_cosine(la2));
    a = mul_q30(s1, s1) + mul_q30(cc, mul_q30(s2, s2));
    if (a > UNIT_Q30) a = UNIT_Q30;
    z = vector_angle(root64(a <<< 30), root64((UNIT_Q30 - a) <<< 30));
    d = (64'sd6371 * z + (64'sd1 <<< 20)) >>> 21;
    return (d > 5242879) ? 5242879 : d;
  endfunction

  // works out the result beat for one accepted check and advances the state
  function automatic verdict_t judge_check(logic nok, logic fix, logic signed [LAT_W-1:0] la,
                                           logic signed [LON_W-1:0] lo, logic [TIME_W-1:0] t);
    verdict_t v;
    longint lat, lon, span;
    logic [TIME_W-1:0] elapsed;
    v.update = 1'b0;
    v.cause = CAUSE_SKIP;
    v.distance = '0;
    if (!nok || !fix) return v;
    lat = longint'(la);
    lon = longint'(lo);
    if (lat > CLAMP_LAT) lat = CLAMP_LAT;
    if (lat < -CLAMP_LAT) lat = -CLAMP_LAT;
    if (lon > CLAMP_LON) lon = CLAMP_LON;
    if (lon < -CLAMP_LON) lon = -CLAMP_LON;
    span = 0;
    if (!last_fix) begin
      v.cause = CAUSE_FIRST;
    end else begin
      span = great_circle(prev_lat, prev_lon, lat, lon);
      elapsed = t - last_time;
      if (span > longint'(thr_reg)) v.cause = CAUSE_MOVED;
      else if (elapsed > {8'd0, intv_reg}) v.cause = CAUSE_EXPIRED;
      else v.cause = CAUSE_NONE;
    end
    if (v.cause != CAUSE_NONE) begin
      prev_lat = lat;
      prev_lon = lon;
      last_time = t;
      last_fix = 1'b1;
    end
    v.update = (v.cause != CAUSE_NONE);
    v.distance = span[DIST_W-1:0];
    return v;
  endfunction

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result.ready <= 1'b0;
      hold_left--;
    end else begin
      result.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checker, compares each accepted beat with the oldest expectation
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst && result.valid && result.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with nothing expected: update %0d cause %0d distance %0d",
               result.update, result.cause, result.distance);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (result.update !== exp_v.update) begin
          $error("update: expected %0d got %0d", exp_v.update, result.update);
          errors++;
        end
        if (result.cause !== exp_v.cause) begin
          $error("cause: expected %0d got %0d", exp_v.cause, result.cause);
          errors++;
        end
        if (result.distance !== exp_v.distance) begin
          $error("distance: expected %0d got %0d", exp_v.distance, result.distance);
          errors++;
        end
      end
    end
  end

  // offers one check beat, with random idle cycles ahead of it
  task automatic send_check(logic nok, logic fix, logic signed [LAT_W-1:0] la,
                            logic signed [LON_W-1:0] lo, logic [TIME_W-1:0] t);
    if ($urandom_range(99) < tx_idle_pct) begin
      check_in.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
    check_in.valid <= 1'b1;
    check_in.network_ok <= nok;
    check_in.fix_valid <= fix;
    check_in.latitude <= la;
    check_in.longitude <= lo;
    check_in.time_ms <= t;
    do @(posedge clk); while (!check_in.ready);
    pending_verdicts.push_back(judge_check(nok, fix, la, lo, t));
  endtask

  // valid check at a given position, time advanced by dt
  task automatic send_at(longint la, longint lo, longint dt);
    now_ms = now_ms + dt[TIME_W-1:0];
    send_check(1'b1, 1'b1, la[LAT_W-1:0], lo[LON_W-1:0], now_ms);
  endtask

  task automatic wait_idle();
    check_in.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one write beat, then write enable low again
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MOVE_THRESHOLD) thr_reg = val[22:0];
    else if (idx == REG_REFRESH_INTERVAL) intv_reg = val;
    @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] thr, logic [CFG_DATA_W-1:0] intv);
    wait_idle();
    write_reg(REG_MOVE_THRESHOLD, thr);
    write_reg(REG_REFRESH_INTERVAL, intv);
    @(posedge clk);
  endtask

  // skipped checks before any fix, with wild field values
  task automatic test_skipped_checks();
    send_check(1'b0, 1'b1, 31'h3fffffff, 32'h7fffffff, 40'hffffffffff);
    send_check(1'b1, 1'b0, 31'h40000000, 32'h80000000, 40'h0);
    send_check(1'b0, 1'b0, 31'h0, 32'h0, 40'h5555555555);
  endtask

  // first fix with latitude beyond the pole, then the coordinate extremes
  task automatic test_extremes();
    now_ms = 40'd1000;
    send_check(1'b1, 1'b1, 31'h3fffffff, 32'h7fffffff, now_ms); // clamps to both limits
    send_at(900000000, 1800000000, 10);                         // same point, no update
    send_check(1'b1, 1'b1, 31'h40000000, 32'h80000000, now_ms); // pole to pole
    send_at(0, 0, 5);
    send_at(0, 1800000000, 5);                                  // half way round the equator
    send_at(0, -1799000000, 5);                                 // short way across 180
    send_at(0, 1799999999, 5);
    send_at(-900000000, -1800000000, 5);
    send_at(450000000, 12345678, 5);
  endtask

  // near moves against the threshold, expiry, both at once, time wrap
  task automatic test_triggers();
    set_regs(32'd7680, 32'd21600000);
    send_at(100000, 100000, 1);
    send_at(2100000, 100000, 1000);         // about 22 km, no update
    send_at(3000000, 100000, 1000);         // about 32 km, moved
    send_at(3000100, 100000, 21600000);     // exactly the interval, no update
    send_at(3000100, 100000, 21600001);     // expired
    send_at(9000000, 100000, 30000000);     // moved and expired, moved wins
    now_ms = 40'hfffffff000;
    send_at(9000000, 100000, 0);            // expired, just short of the wrap point
    send_at(9000000, 100000, 40'h2000);     // elapsed small after wrap
    send_check(1'b0, 1'b0, 31'h0, 32'h0, now_ms);
  endtask

  // register writes at extremes, plus a write to an unused index
  task automatic test_register_extremes();
    set_regs(32'd0, 32'd0);
    send_at(9000000, 100000, 0);            // no move, but time has elapsed since the stored fix
    send_at(9000001, 100000, 0);            // a one-unit step still rounds to zero distance
    send_at(9000001, 100000, 1);            // one ms is past zero interval
    set_regs(32'hffffffff, 32'hffffffff);   // threshold keeps its low bits
    write_reg(REG_UNUSED, 32'h0);
    send_at(-900000000, 1800000000, 40'hffffffff);
    send_at(-900000000, 1800000000, 40'h100000000);
    set_regs(32'h007fffff, 32'h0);
    send_at(900000000, 0, 1);
  endtask

  // one random check: mostly small walks around the last position
  task automatic random_check();
    int sel;
    longint step;
    sel = $urandom_range(99);
    if (sel < 10) begin
      send_check(1'($urandom_range(1)), 1'b0, LAT_W'($urandom), $urandom,
                 TIME_W'({$urandom, $urandom}));
      return;
    end
    if (sel < 14) begin
      send_check(1'b0, 1'b1, LAT_W'($urandom), $urandom, TIME_W'({$urandom, $urandom}));
      return;
    end
    if (sel < 20) begin
      // raw fields, every bit pattern including out of range values
      now_ms = TIME_W'({$urandom, $urandom});
      send_check(1'b1, 1'b1, LAT_W'($urandom), $urandom, now_ms);
      return;
    end
    if (sel < 30) begin
      cur_lat = longint'($urandom_range(1800000000)) - 900000000;
      cur_lon = longint'($urandom) - 2147483648;
      if (cur_lon > CLAMP_LON || cur_lon < -CLAMP_LON) cur_lon = cur_lon / 2;
    end else begin
      step = longint'($urandom_range(6000000)) - 3000000;
      cur_lat += step;
      cur_lon += longint'($urandom_range(6000000)) - 3000000;
      if (cur_lat > CLAMP_LAT || cur_lat < -CLAMP_LAT) cur_lat = -cur_lat / 2;
      if (cur_lon > CLAMP_LON || cur_lon < -CLAMP_LON) cur_lon = -cur_lon / 2;
    end
    case ($urandom_range(3))
      0: send_at(cur_lat, cur_lon, longint'($urandom_range(100)));
      1: send_at(cur_lat, cur_lon, longint'($urandom_range(40000000)));
      2: send_at(cur_lat, cur_lon, longint'(intv_reg) + longint'($urandom_range(2)) - 1);
      default: send_at(cur_lat, cur_lon, longint'({$urandom, $urandom}));
    endcase
  endtask

  task automatic test_random_phase(int n, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n) random_check();
  endtask

  // long receiver hold-off while checks keep being offered
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (6) random_check();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    check_in.valid = 1'b0;
    check_in.network_ok = 1'b0;
    check_in.fix_valid = 1'b0;
    check_in.latitude = '0;
    check_in.longitude = '0;
    check_in.time_ms = '0;
    result.ready = 1'b0;
    errors = 0;
    cycles = 0;
    hold_left = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    prev_lat = 0;
    prev_lon = 0;
    last_fix = 1'b0;
    last_time = '0;
    thr_reg = MOVE_THRESHOLD_RST;
    intv_reg = REFRESH_INTERVAL_RST;
    cur_lat = 0;
    cur_lon = 0;
    now_ms = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_skipped_checks();
    test_extremes();
    test_triggers();
    test_register_extremes();

    // random phases, one register setting each
    set_regs(32'd7680, 32'd21600000);
    test_random_phase(170, 0, 0);
    set_regs($urandom_range(20000), $urandom);
    test_random_phase(170, 61, 0);
    test_backpressure();
    set_regs($urandom, $urandom_range(50000000));
    test_random_phase(170, 0, 61);
    set_regs($urandom_range(3000), 32'd21600000);
    test_random_phase(170, 7, 7);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_verdicts.size());
      errors++;
    end
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/hmrt_pkg.sv
hdl/hmrt_if.sv
hdl/haversine_move_refresh_trigger_top.sv
dv/tb.sv
